>>> hdl/tfn_pkg.sv
// Package for the triangle face normal pipeline.
// Holds the fixed widths, pipeline depth and the per-lane stage types.
// No dependencies.
package tfn_pkg;

  localparam int unsigned CoordWidth     = 16;
  localparam int unsigned NormalFracBits = 14;
  localparam int unsigned OutWidth       = 16;

  localparam int unsigned DiffWidth = CoordWidth + 1;
  localparam int unsigned ProdWidth = 2 * DiffWidth;
  localparam int unsigned CrossWidth = ProdWidth + 1;
  localparam int unsigned MagWidth  = CrossWidth - 1;
  localparam int unsigned SqWidth   = 2 * MagWidth;
  localparam int unsigned SumWidth  = SqWidth + 2;
  localparam int unsigned AccWidth  = SqWidth + 2 * NormalFracBits + 8;
  localparam int unsigned QuotWidth = NormalFracBits + 1;

  localparam int unsigned NumIter   = NormalFracBits + 1;
  localparam int unsigned IterBase  = 6;
  localparam int unsigned OutStage  = IterBase + NumIter + 1;
  localparam int unsigned NumStages = OutStage + 1;

  typedef struct packed {
    logic signed [AccWidth-1:0] rem;
    logic signed [AccWidth-1:0] prod;
    logic [QuotWidth-1:0]       quot;
  } lane_t;

  typedef struct packed {
    logic [2:0] neg;
    logic       degen;
  } ctl_t;

endpackage

>>> hdl/triangle_face_normal.sv
// Top level of the triangle face normal pipeline.
// Depends on tfn_pkg for widths, stage counts and the lane types.
//
// Usage: one triangle (vertices A, B, C) enters on the input channel per
// transaction, qualified by valid_i and ready_o. The unit face normal and a
// degenerate flag leave on the output channel, qualified by valid_o and
// ready_i, one result per triangle and in order.
// The pipeline holds 23 register stages from the accepting edge to valid_o:
// six stages form the edge vectors, the cross product, its
// magnitudes, squares and their sum, one stage sets up the remainders, then
// fifteen stages resolve one quotient bit each by shift-and-subtract against
// the squared length, and a last stage applies the sign.
// Throughput is one triangle per cycle while the output is not stalled; the
// critical path is one wide three-operand add and sign test per iteration stage.
// Reset clears every valid bit, so the pipeline comes out of reset empty.
// When the receiver stalls, the result holds in the output register and
// earlier stages keep moving into empty slots; input is refused only once
// every stage is occupied. Nothing is lost or repeated.
module triangle_face_normal (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 valid_i,
  output logic                                 ready_o,
  input  logic signed [tfn_pkg::CoordWidth-1:0] ax_i,
  input  logic signed [tfn_pkg::CoordWidth-1:0] ay_i,
  input  logic signed [tfn_pkg::CoordWidth-1:0] az_i,
  input  logic signed [tfn_pkg::CoordWidth-1:0] bx_i,
  input  logic signed [tfn_pkg::CoordWidth-1:0] by_coord_i,
  input  logic signed [tfn_pkg::CoordWidth-1:0] bz_i,
  input  logic signed [tfn_pkg::CoordWidth-1:0] cx_i,
  input  logic signed [tfn_pkg::CoordWidth-1:0] cy_i,
  input  logic signed [tfn_pkg::CoordWidth-1:0] cz_i,
  output logic                                 valid_o,
  input  logic                                 ready_i,
  output logic signed [tfn_pkg::OutWidth-1:0]   nx_o,
  output logic signed [tfn_pkg::OutWidth-1:0]   ny_o,
  output logic signed [tfn_pkg::OutWidth-1:0]   nz_o,
  output logic                                 degenerate_o
);
  import tfn_pkg::*;

  logic [NumStages-1:0] vld_q;
  logic [NumStages-1:0] en;

  logic signed [DiffWidth-1:0]  u_q [3];
  logic signed [DiffWidth-1:0]  v_q [3];
  logic signed [ProdWidth-1:0]  pr_q [6];
  logic signed [CrossWidth-1:0] r_q [3];
  logic [MagWidth-1:0]          m_q [3];
  logic [2:0]                   neg3_q, neg4_q, neg5_q;
  logic [SqWidth-1:0]           sq4_q [3];
  logic [SqWidth-1:0]           sq5_q [3];
  logic                         dg4_q, dg5_q;
  logic [SumWidth-1:0]          sum5_q;

  lane_t             lane_q [NumIter+1][3];
  logic [SumWidth-1:0] sum_q [NumIter+1];
  ctl_t              ctl_q  [NumIter+1];

  logic signed [OutWidth-1:0] nx_q, ny_q, nz_q;
  logic                       dg_q;

  always_comb begin
    en[NumStages-1] = !vld_q[NumStages-1] || ready_i;
    for (int i = NumStages - 2; i >= 0; i--) begin
      en[i] = !vld_q[i] || en[i+1];
    end
  end

  assign ready_o = en[0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      if (en[0]) begin
        vld_q[0] <= valid_i;
      end
      for (int i = 1; i < NumStages; i++) begin
        if (en[i]) begin
          vld_q[i] <= vld_q[i-1];
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en[0]) begin
      u_q[0] <= DiffWidth'(ax_i) - DiffWidth'(bx_i);
      u_q[1] <= DiffWidth'(ay_i) - DiffWidth'(by_coord_i);
      u_q[2] <= DiffWidth'(az_i) - DiffWidth'(bz_i);
      v_q[0] <= DiffWidth'(ax_i) - DiffWidth'(cx_i);
      v_q[1] <= DiffWidth'(ay_i) - DiffWidth'(cy_i);
      v_q[2] <= DiffWidth'(az_i) - DiffWidth'(cz_i);
    end
    if (en[1]) begin
      pr_q[0] <= ProdWidth'(u_q[1]) * ProdWidth'(v_q[2]);
      pr_q[1] <= ProdWidth'(v_q[1]) * ProdWidth'(u_q[2]);
      pr_q[2] <= ProdWidth'(v_q[0]) * ProdWidth'(u_q[2]);
      pr_q[3] <= ProdWidth'(u_q[0]) * ProdWidth'(v_q[2]);
      pr_q[4] <= ProdWidth'(u_q[0]) * ProdWidth'(v_q[1]);
      pr_q[5] <= ProdWidth'(v_q[0]) * ProdWidth'(u_q[1]);
    end
    if (en[2]) begin
      r_q[0] <= CrossWidth'(pr_q[0]) - CrossWidth'(pr_q[1]);
      r_q[1] <= CrossWidth'(pr_q[2]) - CrossWidth'(pr_q[3]);
      r_q[2] <= CrossWidth'(pr_q[4]) - CrossWidth'(pr_q[5]);
    end
    if (en[3]) begin
      for (int c = 0; c < 3; c++) begin
        neg3_q[c] <= r_q[c][CrossWidth-1];
        m_q[c]    <= r_q[c][CrossWidth-1] ? MagWidth'(-r_q[c]) : MagWidth'(r_q[c]);
      end
    end
    if (en[4]) begin
      for (int c = 0; c < 3; c++) begin
        sq4_q[c] <= SqWidth'(m_q[c]) * SqWidth'(m_q[c]);
      end
      neg4_q <= neg3_q;
      dg4_q  <= (m_q[0] == '0) && (m_q[1] == '0) && (m_q[2] == '0);
    end
    if (en[5]) begin
      sum5_q <= SumWidth'(sq4_q[0]) + SumWidth'(sq4_q[1]) + SumWidth'(sq4_q[2]);
      sq5_q  <= sq4_q;
      neg5_q <= neg4_q;
      dg5_q  <= dg4_q;
    end
    if (en[IterBase]) begin
      for (int c = 0; c < 3; c++) begin
        lane_q[0][c].rem  <= signed'(AccWidth'(sq5_q[c]) << (2 * NormalFracBits + 2))
                             - signed'(AccWidth'(sum5_q));
        lane_q[0][c].prod <= -signed'(AccWidth'(sum5_q));
        lane_q[0][c].quot <= '0;
      end
      sum_q[0]       <= sum5_q;
      ctl_q[0].neg   <= neg5_q;
      ctl_q[0].degen <= dg5_q;
    end
  end

  for (genvar j = 0; j < NumIter; j++) begin : g_iter
    localparam int unsigned K = NumIter - 1 - j;
    logic signed [AccWidth-1:0] trial [3];

    always_comb begin
      for (int c = 0; c < 3; c++) begin
        trial[c] = lane_q[j][c].rem - (lane_q[j][c].prod <<< (K + 2))
                   - signed'(AccWidth'(sum_q[j]) << (2 * K + 2));
      end
    end

    always_ff @(posedge clk_i) begin
      if (en[IterBase+j+1]) begin
        for (int c = 0; c < 3; c++) begin
          if (!trial[c][AccWidth-1]) begin
            lane_q[j+1][c].rem  <= trial[c];
            lane_q[j+1][c].prod <= lane_q[j][c].prod
                                   + signed'(AccWidth'(sum_q[j]) << (K + 1));
            lane_q[j+1][c].quot <= lane_q[j][c].quot | (QuotWidth'(1) << K);
          end else begin
            lane_q[j+1][c] <= lane_q[j][c];
          end
        end
        sum_q[j+1] <= sum_q[j];
        ctl_q[j+1] <= ctl_q[j];
      end
    end
  end

  function automatic logic signed [OutWidth-1:0] apply_sign(
    input logic [QuotWidth-1:0] quot,
    input logic                 neg,
    input logic                 degen
  );
    logic signed [QuotWidth:0] s;
    s = signed'({1'b0, quot});
    if (degen) begin
      return '0;
    end
    return neg ? OutWidth'(-s) : OutWidth'(s);
  endfunction

  always_ff @(posedge clk_i) begin
    if (en[OutStage]) begin
      nx_q <= apply_sign(lane_q[NumIter][0].quot, ctl_q[NumIter].neg[0],
                         ctl_q[NumIter].degen);
      ny_q <= apply_sign(lane_q[NumIter][1].quot, ctl_q[NumIter].neg[1],
                         ctl_q[NumIter].degen);
      nz_q <= apply_sign(lane_q[NumIter][2].quot, ctl_q[NumIter].neg[2],
                         ctl_q[NumIter].degen);
      dg_q <= ctl_q[NumIter].degen;
    end
  end

  assign valid_o      = vld_q[OutStage];
  assign nx_o         = nx_q;
  assign ny_o         = ny_q;
  assign nz_o         = nz_q;
  assign degenerate_o = dg_q;

  a_degen_zero : assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o && degenerate_o |-> nx_o == '0 && ny_o == '0 && nz_o == '0)
    else $error("degenerate result with non-zero normal");

  a_normal_nonzero : assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o && !degenerate_o |-> nx_o != '0 || ny_o != '0 || nz_o != '0)
    else $error("non-degenerate result with zero normal");

  a_free_slot : assert property (@(posedge clk_i) disable iff (!rst_ni)
    !vld_q[OutStage] |-> ready_o)
    else $error("input refused while the output stage is empty");

  a_x_range : assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o |-> nx_o <= 16384 && nx_o >= -16384)
    else $error("normal component out of range");

endmodule

>>> bench/triangle_face_normal_checker.sv
// Checker for the triangle face normal block: watches both channels, predicts each
// normal from the accepted triangle and compares it with the returned result.
// Depends on tfn_pkg for the coordinate and output widths and the fraction bits.
module triangle_face_normal_checker (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  logic                                  valid_i,
  input  logic                                  ready_o,
  input  logic signed [tfn_pkg::CoordWidth-1:0] ax_i,
  input  logic signed [tfn_pkg::CoordWidth-1:0] ay_i,
  input  logic signed [tfn_pkg::CoordWidth-1:0] az_i,
  input  logic signed [tfn_pkg::CoordWidth-1:0] bx_i,
  input  logic signed [tfn_pkg::CoordWidth-1:0] by_coord_i,
  input  logic signed [tfn_pkg::CoordWidth-1:0] bz_i,
  input  logic signed [tfn_pkg::CoordWidth-1:0] cx_i,
  input  logic signed [tfn_pkg::CoordWidth-1:0] cy_i,
  input  logic signed [tfn_pkg::CoordWidth-1:0] cz_i,
  input  logic                                  valid_o,
  input  logic                                  ready_i,
  input  logic signed [tfn_pkg::OutWidth-1:0]   nx_o,
  input  logic signed [tfn_pkg::OutWidth-1:0]   ny_o,
  input  logic signed [tfn_pkg::OutWidth-1:0]   nz_o,
  input  logic                                  degenerate_o,
  output int                                    fail_count_o,
  output int                                    pending_o
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct {
    logic [tfn_pkg::OutWidth-1:0] nx;
    logic [tfn_pkg::OutWidth-1:0] ny;
    logic [tfn_pkg::OutWidth-1:0] nz;
    logic                         degen;
  } normal_t;

  normal_t expected_normals[$];
  int      fail_count = 0;

  function automatic logic [tfn_pkg::OutWidth-1:0] rounded_component(longint c,
                                                                      bit [127:0] sumsq);
    longint     mag;
    bit [127:0] m;
    bit [127:0] lhs;
    bit [127:0] k;
    longint     lo;
    longint     hi;
    longint     mid;
    mag = (c < 0) ? -c : c;
    m   = 128'(mag);
    lhs = (m * m) << (2 * tfn_pkg::NormalFracBits + 2);
    lo  = 0;
    hi  = longint'(1) << tfn_pkg::NormalFracBits;
    while (lo < hi) begin
      mid = (lo + hi + 1) >>> 1;
      k   = 128'(2 * mid - 1);
      if (lhs >= k * k * sumsq) lo = mid;
      else hi = mid - 1;
    end
    if (c < 0) lo = -lo;
    return lo[tfn_pkg::OutWidth-1:0];
  endfunction

  function automatic normal_t face_normal(longint a0, longint a1, longint a2,
                                          longint b0, longint b1, longint b2,
                                          longint c0, longint c1, longint c2);
    normal_t    n;
    longint     u0, u1, u2, v0, v1, v2, r0, r1, r2;
    bit [127:0] sumsq;
    u0 = a0 - b0; u1 = a1 - b1; u2 = a2 - b2;
    v0 = a0 - c0; v1 = a1 - c1; v2 = a2 - c2;
    r0 = u1 * v2 - v1 * u2;
    r1 = v0 * u2 - u0 * v2;
    r2 = u0 * v1 - v0 * u1;
    n  = '{nx: '0, ny: '0, nz: '0, degen: 1'b1};
    if (r0 != 0 || r1 != 0 || r2 != 0) begin
      sumsq   = 128'(r0) * 128'(r0) + 128'(r1) * 128'(r1) + 128'(r2) * 128'(r2);
      n.nx    = rounded_component(r0, sumsq);
      n.ny    = rounded_component(r1, sumsq);
      n.nz    = rounded_component(r2, sumsq);
      n.degen = 1'b0;
    end
    return n;
  endfunction

  task automatic report(string what, logic [31:0] got, logic [31:0] want);
    $display("%0t: mismatch on %s: got %0h, expected %0h", $time, what, got, want);
    fail_count++;
  endtask

  assign fail_count_o = fail_count;

  always @(posedge clk_i) begin
    normal_t want;
    if (rst_ni) begin
      if (valid_i && ready_o) begin
        expected_normals = {expected_normals,
                            face_normal(ax_i, ay_i, az_i, bx_i, by_coord_i, bz_i,
                                        cx_i, cy_i, cz_i)};
      end
      if (valid_o && ready_i) begin
        if (expected_normals.size() == 0) begin
          report("unexpected transaction", 32'(nx_o), 32'hx);
        end else begin
          want = expected_normals.pop_front();
          if (nx_o !== want.nx) report("nx", 32'(nx_o), 32'(want.nx));
          if (ny_o !== want.ny) report("ny", 32'(ny_o), 32'(want.ny));
          if (nz_o !== want.nz) report("nz", 32'(nz_o), 32'(want.nz));
          if (degenerate_o !== want.degen) report("degenerate", 32'(degenerate_o),
                                                  32'(want.degen));
        end
      end
    end
    pending_o = expected_normals.size();
  end
endmodule

>>> bench/tb_triangle_face_normal.sv
// Testbench top for the triangle face normal block: drives directed and random
// triangles in bursts, stalls the result side and gives the verdict.
// Depends on tfn_pkg, triangle_face_normal and triangle_face_normal_checker.
module tb_triangle_face_normal;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned CW = tfn_pkg::CoordWidth;
  localparam int RandomTriangles = 750;
  localparam int IdleLimit = 2000;

  logic                 clk_i = 1'b0;
  logic                 rst_ni = 1'b0;
  logic                 valid_i = 1'b0;
  logic                 ready_o;
  logic signed [CW-1:0] ax_i = '0, ay_i = '0, az_i = '0;
  logic signed [CW-1:0] bx_i = '0, by_coord_i = '0, bz_i = '0;
  logic signed [CW-1:0] cx_i = '0, cy_i = '0, cz_i = '0;
  logic                 valid_o;
  logic                 ready_i = 1'b0;
  logic signed [tfn_pkg::OutWidth-1:0] nx_o, ny_o, nz_o;
  logic                 degenerate_o;
  int                   fail_count;
  int                   pending;
  int                   idle_cycles = 0;
  int                   burst_left = 0;

  always #5 clk_i = ~clk_i;

  triangle_face_normal i_dut (.*);
  triangle_face_normal_checker i_checker (.*, .fail_count_o(fail_count),
                                          .pending_o(pending));

  // The result side switches between free running, light and heavy stalling.
  int stall_mode = 0;
  always @(posedge clk_i) begin
    if ($urandom_range(0, 63) == 0) stall_mode <= $urandom_range(0, 2);
    case (stall_mode)
      0: ready_i <= 1'b1;
      1: ready_i <= ($urandom_range(0, 3) != 0);
      default: ready_i <= ($urandom_range(0, 3) == 0);
    endcase
  end

  always @(posedge clk_i) begin
    if ((valid_i && ready_o) || (valid_o && ready_i)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= IdleLimit) begin
      $display("tb_triangle_face_normal failed");
      $finish;
    end
  end

  task automatic send_triangle(logic signed [CW-1:0] a0, a1, a2, b0, b1, b2, c0, c1, c2);
    if (burst_left == 0) begin
      valid_i <= 1'b0;
      repeat ($urandom_range(1, 12)) @(posedge clk_i);
      burst_left = $urandom_range(1, 30);
    end
    ax_i <= a0; ay_i <= a1; az_i <= a2;
    bx_i <= b0; by_coord_i <= b1; bz_i <= b2;
    cx_i <= c0; cy_i <= c1; cz_i <= c2;
    valid_i <= 1'b1;
    do @(negedge clk_i); while (!ready_o);
    @(posedge clk_i);
    burst_left--;
  endtask

  task automatic wait_drained();
    do @(negedge clk_i); while (pending != 0);
    @(posedge clk_i);
  endtask

  function automatic logic signed [CW-1:0] rnd_coord(int span);
    return CW'($signed($urandom_range(0, 2 * span)) - span);
  endfunction

  function automatic logic signed [CW-1:0] edge_value();
    case ($urandom_range(0, 4))
      0: return -16'sd32768;
      1: return 16'sd32767;
      2: return 16'sd0;
      3: return -16'sd1;
      default: return 16'sd1;
    endcase
  endfunction

  initial begin
    logic signed [CW-1:0] a[3], b[3], c[3], d[3];
    int k;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    send_triangle(0, 0, 0, 0, 0, 0, 0, 0, 0);
    send_triangle(0, 0, 0, 1, 0, 0, 0, 1, 0);
    send_triangle(0, 0, 0, 0, 1, 0, 0, 0, 1);
    send_triangle(0, 0, 0, 0, 0, 1, 1, 0, 0);
    send_triangle(0, 0, 0, 1, 1, 1, 2, 2, 2);
    send_triangle(5, 5, 5, 5, 5, 5, 9, 1, 3);
    send_triangle(-32768, -32768, -32768, 32767, 32767, -32768, 32767, -32768, 32767);
    send_triangle(32767, 32767, 32767, -32768, -32768, 32767, -32768, 32767, -32768);
    send_triangle(-32768, 0, 0, 32767, 0, 0, 0, 32767, 0);
    send_triangle(32767, 32767, 32767, -32768, -32768, -32768, 32767, -32768, 0);
    send_triangle(0, 0, 0, 3, 0, 0, 0, 4, 0);
    send_triangle(0, 0, 0, 1, 0, 0, 1, 1, 1);
    send_triangle(0, 0, 0, 2, 1, 0, 0, 1, 2);
    send_triangle(1, 2, 3, -4, 5, -6, 7, -8, 9);
    send_triangle(-1, -1, -1, 1, 1, 1, -1, 1, -1);
    send_triangle(100, 200, 300, 100, 200, 300, 100, 200, 300);
    send_triangle(-32768, -32768, -32768, -32768, -32768, -32768, 32767, 32767, 32767);
    send_triangle(0, 0, 0, 1, 2, 0, 2, 4, 0);

    // Let everything drain before the random part starts.
    valid_i <= 1'b0;
    burst_left = 0;
    wait_drained();

    for (int i = 0; i < RandomTriangles; i++) begin
      case ($urandom_range(0, 9))
        0, 1, 2: for (int j = 0; j < 3; j++) begin
          a[j] = CW'($urandom); b[j] = CW'($urandom); c[j] = CW'($urandom);
        end
        3, 4: for (int j = 0; j < 3; j++) begin
          a[j] = rnd_coord(20000);
          b[j] = a[j] + rnd_coord(200);
          c[j] = a[j] + rnd_coord(200);
        end
        5: for (int j = 0; j < 3; j++) begin
          a[j] = rnd_coord(4); b[j] = rnd_coord(4); c[j] = rnd_coord(4);
        end
        6, 7: begin
          k = $urandom_range(0, 100) - 50;
          for (int j = 0; j < 3; j++) begin
            a[j] = rnd_coord(10000);
            d[j] = rnd_coord(100);
            b[j] = a[j] + d[j];
            c[j] = a[j] + CW'(k) * d[j];
          end
        end
        8: for (int j = 0; j < 3; j++) begin
          a[j] = CW'($urandom); c[j] = CW'($urandom);
          b[j] = ($urandom_range(0, 1) != 0) ? a[j] : c[j];
        end
        default: for (int j = 0; j < 3; j++) begin
          a[j] = edge_value(); b[j] = edge_value(); c[j] = edge_value();
        end
      endcase
      send_triangle(a[0], a[1], a[2], b[0], b[1], b[2], c[0], c[1], c[2]);
    end
    valid_i <= 1'b0;
    wait_drained();
    repeat (30) @(posedge clk_i);
    if (fail_count == 0) begin
      $display("tb_triangle_face_normal passed");
    end else begin
      $display("tb_triangle_face_normal failed");
    end
    $finish;
  end
endmodule
